/* rtl/core/flc_pkg.sv */
// Shared constants and control types for the full linear convolution unit.
`default_nettype none

package flc_pkg;

    localparam int MAX_TAPS_DEF = 64;   // default kernel capacity
    localparam int DATA_W       = 32;   // sample, kernel and result width
    localparam int IDX_W        = 6;    // tap_index field width
    localparam int TAP_CNT_W    = 7;    // tap_count register width
    localparam int S_TDATA_W    = 40;   // tap_index + value, padded to bytes
    localparam int M_TDATA_W    = 32;   // result

    // Controls shared by every cell of the ring
    typedef struct packed {
        logic clr;    // zero the sample
        logic push;   // take the sample from the previous cell
        logic rot;    // take sample and kernel from the next cell (ring)
    } t_cell_ctl;

    // Controls of the multiply-accumulate unit
    typedef struct packed {
        logic prod_en;    // load the product register
        logic prod_use;   // tap lies inside the active kernel, else load zero
        logic acc_clr;    // start a new sum
        logic acc_en;     // add the registered product
    } t_mac_ctl;

endpackage

`default_nettype wire

/* rtl/core/flc_cell.sv */
// One cell of the ring: holds one delayed sample and one kernel element.
`default_nettype none

module flc_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire flc_pkg::t_cell_ctl         i_ctl,
    input  wire logic                       i_kern_we,
    input  wire logic [flc_pkg::DATA_W-1:0] i_kern_data,
    input  wire logic [flc_pkg::DATA_W-1:0] i_prev_samp,
    input  wire logic [flc_pkg::DATA_W-1:0] i_next_samp,
    input  wire logic [flc_pkg::DATA_W-1:0] i_next_kern,
    output logic      [flc_pkg::DATA_W-1:0] o_samp,
    output logic      [flc_pkg::DATA_W-1:0] o_kern
);

    logic [flc_pkg::DATA_W-1:0] r_samp;
    logic [flc_pkg::DATA_W-1:0] r_kern;

    // Delay line contents are part of the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samp <= '0;
        end else if (i_ctl.clr) begin
            r_samp <= '0;
        end else if (i_ctl.push) begin
            r_samp <= i_prev_samp;
        end else if (i_ctl.rot) begin
            r_samp <= i_next_samp;
        end
    end

    // Kernel is undefined until loaded
    always_ff @(posedge i_clk) begin
        if (i_kern_we) begin
            r_kern <= i_kern_data;
        end else if (i_ctl.rot) begin
            r_kern <= i_next_kern;
        end
    end

    assign o_samp = r_samp;
    assign o_kern = r_kern;

endmodule

`default_nettype wire

/* rtl/core/flc_mac.sv */
// Multiply-accumulate unit at the head of the ring, wrapping modulo 2^32.
`default_nettype none

module flc_mac (
    input  wire logic                       i_clk,
    input  wire flc_pkg::t_mac_ctl          i_ctl,
    input  wire logic [flc_pkg::DATA_W-1:0] i_samp,
    input  wire logic [flc_pkg::DATA_W-1:0] i_kern,
    output logic      [flc_pkg::DATA_W-1:0] o_sum
);

    logic [flc_pkg::DATA_W-1:0] w_prod;
    logic [flc_pkg::DATA_W-1:0] r_prod;
    logic [flc_pkg::DATA_W-1:0] r_acc;

    // Low half of the product only; the sum wraps anyway
    assign w_prod = i_samp * i_kern;

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod <= i_ctl.prod_use ? w_prod : '0;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // Fold in the last product on the way out
    assign o_sum = r_acc + r_prod;

endmodule

`default_nettype wire

/* rtl/core/full_linear_convolution_i32_unit.sv */
// Top level of the full linear convolution unit: ring of tap cells and sequencer.
`default_nettype none

// Streams the full linear convolution y[n] = sum_k B[k]*A[n-k] of a signed 32-bit
// signal with a kernel of up to MAX_TAPS elements; all products and sums wrap modulo
// 2^32. Load the kernel first with s_axis_tuser = 0 (one element per transaction,
// position in tap_index; positions at or beyond MAX_TAPS are dropped), set the number
// of elements in use through the config channel (0 acts as 1, above MAX_TAPS acts as
// MAX_TAPS), then send signal samples with s_axis_tuser = 1. Each sample yields one
// result; the sample carrying s_axis_tlast also yields one tail result fewer than the
// elements in use, as if zeros followed, marks the very last one with m_axis_tlast,
// and then clears the delay line for the next signal. The kernel and the delay line
// live in a ring of MAX_TAPS cells; for each result the ring rotates once past a
// single multiply-accumulate unit at its head. A new sample is accepted only once
// the previous result, with its tail, has been handed to the output register; a
// kernel element is accepted whenever the unit is idle. A finished result waits in
// the output register while the next one is computed. Write the config only while
// the unit is idle.

module full_linear_convolution_i32_unit #(
    parameter int MAX_TAPS = flc_pkg::MAX_TAPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    // Config channel: tap_count
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [flc_pkg::TAP_CNT_W-1:0] i_cfg_data,

    // Input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [flc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [5:0] tap_index,
                                                              // [37:6] value, [39:38] zero
    input  wire logic                          s_axis_tuser,  // mode: 0 kernel, 1 sample
    input  wire logic                          s_axis_tlast,  // last_sample

    // Output stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [flc_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [31:0] result
    output logic                               m_axis_tlast   // final_output
);

    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int DW    = flc_pkg::DATA_W;
    localparam int IW    = flc_pkg::IDX_W;
    localparam int TW    = flc_pkg::TAP_CNT_W;

    typedef enum logic {
        S_IDLE,
        S_CALC
    } t_state;

    // ---------------------------------------------------------------- registers
    t_state               r_state,   n_state;
    logic [CNT_W-1:0]     r_cnt,     n_cnt;      // rotation step within one result
    logic [CNT_W-1:0]     r_taps,    n_taps;     // effective kernel length
    logic [CNT_W-1:0]     r_remain,  n_remain;   // tail results still owed
    logic                 r_last,    n_last;     // current run ends the signal
    logic                 r_out_vld, n_out_vld;
    logic [DW-1:0]        r_out_dat, n_out_dat;
    logic                 r_out_lst, n_out_lst;
    logic [TW-1:0]        r_tap_count;

    // ---------------------------------------------------------------- decode
    logic [IW-1:0]        w_idx;
    logic [DW-1:0]        w_value;
    logic                 w_in_acc;
    logic                 w_samp_acc;
    logic                 w_kern_we;
    logic [CNT_W-1:0]     w_eff;
    logic                 w_out_free;
    logic                 w_rot;
    logic                 w_done;
    logic                 w_push_zero;
    logic                 w_final;
    logic [DW-1:0]        w_push_val;
    logic [DW-1:0]        w_sum;

    flc_pkg::t_cell_ctl   w_cell_ctl;
    flc_pkg::t_mac_ctl    w_mac_ctl;

    logic [DW-1:0]        w_samp [MAX_TAPS];
    logic [DW-1:0]        w_kern [MAX_TAPS];

    assign w_idx   = s_axis_tdata[IW-1:0];
    assign w_value = s_axis_tdata[IW+DW-1:IW];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_samp_acc = w_in_acc && s_axis_tuser;
    assign w_kern_we  = w_in_acc && !s_axis_tuser && ({1'b0, w_idx} < TW'(MAX_TAPS));

    // Zero acts as one, anything past the ring acts as a full ring
    always_comb begin
        if (r_tap_count == '0) begin
            w_eff = CNT_W'(1);
        end else if (r_tap_count > TW'(MAX_TAPS)) begin
            w_eff = CNT_W'(MAX_TAPS);
        end else begin
            w_eff = CNT_W'(r_tap_count);
        end
    end

    // Rotate the ring once past the MAC, then hand the sum to the output register
    assign w_out_free  = !r_out_vld || m_axis_tready;
    assign w_rot       = (r_state == S_CALC) && (r_cnt < CNT_W'(MAX_TAPS));
    assign w_done      = (r_state == S_CALC) && (r_cnt == CNT_W'(MAX_TAPS)) && w_out_free;
    assign w_push_zero = w_done && (r_remain != '0);
    assign w_final     = r_last && (r_remain == '0);
    assign w_push_val  = w_samp_acc ? w_value : '0;

    assign w_cell_ctl.clr  = w_done && w_final;
    assign w_cell_ctl.push = w_samp_acc || w_push_zero;
    assign w_cell_ctl.rot  = w_rot;

    assign w_mac_ctl.prod_en  = w_rot;
    assign w_mac_ctl.prod_use = (r_cnt < r_taps);
    assign w_mac_ctl.acc_clr  = w_rot && (r_cnt == '0);
    assign w_mac_ctl.acc_en   = w_rot && (r_cnt != '0);

    // ---------------------------------------------------------------- ring of cells
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        flc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_cell_ctl),
            .i_kern_we   (w_kern_we && (w_idx == IW'(k))),
            .i_kern_data (w_value),
            .i_prev_samp ((k == 0) ? w_push_val : w_samp[(k + MAX_TAPS - 1) % MAX_TAPS]),
            .i_next_samp (w_samp[(k + 1) % MAX_TAPS]),
            .i_next_kern (w_kern[(k + 1) % MAX_TAPS]),
            .o_samp      (w_samp[k]),
            .o_kern      (w_kern[k])
        );
    end

    flc_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_samp (w_samp[0]),
        .i_kern (w_kern[0]),
        .o_sum  (w_sum)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_taps    = r_taps;
        n_remain  = r_remain;
        n_last    = r_last;
        n_out_vld = r_out_vld;
        n_out_dat = r_out_dat;
        n_out_lst = r_out_lst;

        // Drop the output once the sink takes it
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_samp_acc) begin
                    n_state  = S_CALC;
                    n_cnt    = '0;
                    n_taps   = w_eff;
                    n_remain = s_axis_tlast ? (w_eff - CNT_W'(1)) : '0;
                    n_last   = s_axis_tlast;
                end
            end
            S_CALC: begin
                if (w_rot) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (w_done) begin
                    n_out_vld = 1'b1;
                    n_out_dat = w_sum;
                    n_out_lst = w_final;
                    if (w_push_zero) begin
                        // Advance the tail: one zero enters, start the next result
                        n_remain = r_remain - CNT_W'(1);
                        n_cnt    = '0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_taps      <= CNT_W'(1);
            r_remain    <= '0;
            r_last      <= 1'b0;
            r_out_vld   <= 1'b0;
            r_tap_count <= TW'(1);
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_taps    <= n_taps;
            r_remain  <= n_remain;
            r_last    <= n_last;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tap_count <= i_cfg_data;
            end
        end
        r_out_dat <= n_out_dat;
        r_out_lst <= n_out_lst;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_dat;
    assign m_axis_tlast  = r_out_lst;

    // ---------------------------------------------------------------- assertions
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_TAPS))
        else $error("rotation step beyond ring length");

    a_taps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_taps != '0) && (r_taps <= CNT_W'(MAX_TAPS))
                                && (r_remain < r_taps))
        else $error("tap or tail count out of range");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_final) |=> (r_state == S_IDLE) && (w_samp[0] == '0)
                                && r_out_vld && r_out_lst)
        else $error("final result did not clear the delay line");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |-> !w_done)
        else $error("result loaded over a pending one");

endmodule

`default_nettype wire
